// ===== sv/clcd_pkg.sv =====
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared types, codes and the control store for the character-LCD nibble
// command encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package clcd_pkg;

    // Command codes carried on s_tuser
    localparam logic [2:0] FUNC_INIT      = 3'd0;
    localparam logic [2:0] FUNC_PRINT     = 3'd1;
    localparam logic [2:0] FUNC_CLEAR     = 3'd2;
    localparam logic [2:0] FUNC_BACKLIGHT = 3'd3;
    localparam logic [2:0] FUNC_GLYPH     = 3'd4;

    // Highest legal print column
    localparam logic [4:0] COL_MAX = 5'd15;

    // Nibble source select
    localparam logic [2:0] SRC_CONST   = 3'd0;
    localparam logic [2:0] SRC_ADDR_HI = 3'd1;
    localparam logic [2:0] SRC_ADDR_LO = 3'd2;
    localparam logic [2:0] SRC_CHAR_HI = 3'd3;
    localparam logic [2:0] SRC_CHAR_LO = 3'd4;
    localparam logic [2:0] SRC_LASTNIB = 3'd5;
    localparam logic [2:0] SRC_ROW_HI  = 3'd6;
    localparam logic [2:0] SRC_ROW_LO  = 3'd7;

    // Beat phase within one nibble
    localparam logic [1:0] PH_WRITE  = 2'd0;
    localparam logic [1:0] PH_STROBE = 2'd1;
    localparam logic [1:0] PH_HOLD   = 2'd2;

    localparam logic [2:0] ROW_LAST = 3'd7;

    // Program entry points
    localparam int PC_W = 5;
    localparam logic [PC_W-1:0] PC_INIT      = 5'd0;
    localparam logic [PC_W-1:0] PC_PRINT     = 5'd12;
    localparam logic [PC_W-1:0] PC_CLEAR     = 5'd16;
    localparam logic [PC_W-1:0] PC_BACKLIGHT = 5'd18;
    localparam logic [PC_W-1:0] PC_GLYPH     = 5'd19;
    localparam logic [PC_W-1:0] PC_ROW_LOOP  = 5'd21;
    localparam logic [PC_W-1:0] PC_ERROR     = 5'd23;

    // One control word per nibble step
    typedef struct packed {
        logic [2:0]      src;
        logic [3:0]      konst;
        logic            rs;
        logic            last;
        logic            loop;
        logic            err;
        logic [PC_W-1:0] target;
    } ctrl_t;

    // Captured command
    typedef struct packed {
        logic [2:0]  func;
        logic        bad;
        logic [7:0]  addr;
        logic [7:0]  char_code;
        logic        backlight_on;
        logic [63:0] pattern;
    } cmd_t;

    // One expander beat
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       error;
    } beat_t;

    function automatic ctrl_t mk(input logic [2:0] src, input logic [3:0] konst,
                                 input logic rs, input logic last);
        ctrl_t c;
        c        = '0;
        c.src    = src;
        c.konst  = konst;
        c.rs     = rs;
        c.last   = last;
        return c;
    endfunction

    // Control store
    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t c;
        c = '0;
        case (pc)
            // init: 3,3,3,2 then 0x28, 0x0C, 0x01, 0x06
            5'd0:  c = mk(SRC_CONST, 4'h3, 1'b0, 1'b0);
            5'd1:  c = mk(SRC_CONST, 4'h3, 1'b0, 1'b0);
            5'd2:  c = mk(SRC_CONST, 4'h3, 1'b0, 1'b0);
            5'd3:  c = mk(SRC_CONST, 4'h2, 1'b0, 1'b0);
            5'd4:  c = mk(SRC_CONST, 4'h2, 1'b0, 1'b0);
            5'd5:  c = mk(SRC_CONST, 4'h8, 1'b0, 1'b0);
            5'd6:  c = mk(SRC_CONST, 4'h0, 1'b0, 1'b0);
            5'd7:  c = mk(SRC_CONST, 4'hC, 1'b0, 1'b0);
            5'd8:  c = mk(SRC_CONST, 4'h0, 1'b0, 1'b0);
            5'd9:  c = mk(SRC_CONST, 4'h1, 1'b0, 1'b0);
            5'd10: c = mk(SRC_CONST, 4'h0, 1'b0, 1'b0);
            5'd11: c = mk(SRC_CONST, 4'h6, 1'b0, 1'b1);
            // print: DDRAM address, then the character as data
            5'd12: c = mk(SRC_ADDR_HI, 4'h0, 1'b0, 1'b0);
            5'd13: c = mk(SRC_ADDR_LO, 4'h0, 1'b0, 1'b0);
            5'd14: c = mk(SRC_CHAR_HI, 4'h0, 1'b1, 1'b0);
            5'd15: c = mk(SRC_CHAR_LO, 4'h0, 1'b1, 1'b1);
            // clear display
            5'd16: c = mk(SRC_CONST, 4'h0, 1'b0, 1'b0);
            5'd17: c = mk(SRC_CONST, 4'h1, 1'b0, 1'b1);
            // backlight: resend the stored nibble
            5'd18: c = mk(SRC_LASTNIB, 4'h0, 1'b0, 1'b1);
            // glyph: CGRAM address, then eight rows
            5'd19: c = mk(SRC_ADDR_HI, 4'h0, 1'b0, 1'b0);
            5'd20: c = mk(SRC_ADDR_LO, 4'h0, 1'b0, 1'b0);
            5'd21: c = mk(SRC_ROW_HI, 4'h0, 1'b1, 1'b0);
            5'd22: begin
                c        = mk(SRC_ROW_LO, 4'h0, 1'b1, 1'b1);
                c.loop   = 1'b1;
                c.target = PC_ROW_LOOP;
            end
            // rejected command: one zero beat
            5'd23: begin
                c      = mk(SRC_CONST, 4'h0, 1'b0, 1'b1);
                c.err  = 1'b1;
            end
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/clcd_seq.sv =====
// ----------------------------------------------------------------------------
// clcd_seq
// Microcoded nibble sequencer: one beat per cycle unless stalled, three beats
// per nibble; walks the control store, keeps backlight and last-nibble state.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_seq (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  start,
    input  clcd_pkg::cmd_t       cmd,
    input  wire                  beat_take,
    output logic                 busy,
    output logic                 beat_valid,
    output clcd_pkg::beat_t      beat
);

    logic                       busy_reg, busy_next;
    logic [clcd_pkg::PC_W-1:0]  pc_reg, pc_next;
    logic [1:0]                 phase_reg, phase_next;
    logic [2:0]                 row_reg, row_next;
    logic                       bl_reg, bl_next;
    logic [3:0]                 lastnib_reg, lastnib_next;
    clcd_pkg::cmd_t             cmd_reg;

    clcd_pkg::ctrl_t            ctrl;
    logic [3:0]                 nib;
    logic [7:0]                 row_byte;
    logic                       fire;
    logic                       step_end;
    logic                       jump;
    logic [clcd_pkg::PC_W-1:0]  entry;

    assign ctrl     = clcd_pkg::ucode(pc_reg);
    assign fire     = busy_reg && beat_take;
    assign row_byte = cmd_reg.pattern[row_reg*8 +: 8];
    assign step_end = ctrl.err || (phase_reg == clcd_pkg::PH_HOLD);
    assign jump     = ctrl.loop && (row_reg != clcd_pkg::ROW_LAST);

    // Nibble source mux
    always_comb begin
        case (ctrl.src)
            clcd_pkg::SRC_CONST:   nib = ctrl.konst;
            clcd_pkg::SRC_ADDR_HI: nib = cmd_reg.addr[7:4];
            clcd_pkg::SRC_ADDR_LO: nib = cmd_reg.addr[3:0];
            clcd_pkg::SRC_CHAR_HI: nib = cmd_reg.char_code[7:4];
            clcd_pkg::SRC_CHAR_LO: nib = cmd_reg.char_code[3:0];
            clcd_pkg::SRC_LASTNIB: nib = lastnib_reg;
            clcd_pkg::SRC_ROW_HI:  nib = row_byte[7:4];
            clcd_pkg::SRC_ROW_LO:  nib = row_byte[3:0];
            default:               nib = 4'h0;
        endcase
    end

    // Entry point from the command
    always_comb begin
        if (cmd.bad) begin
            entry = clcd_pkg::PC_ERROR;
        end else begin
            case (cmd.func)
                clcd_pkg::FUNC_INIT:      entry = clcd_pkg::PC_INIT;
                clcd_pkg::FUNC_PRINT:     entry = clcd_pkg::PC_PRINT;
                clcd_pkg::FUNC_CLEAR:     entry = clcd_pkg::PC_CLEAR;
                clcd_pkg::FUNC_BACKLIGHT: entry = clcd_pkg::PC_BACKLIGHT;
                default:                  entry = clcd_pkg::PC_GLYPH;
            endcase
        end
    end

    // Beat formatting: nibble | backlight | enable | rw | rs
    always_comb begin
        if (ctrl.err) begin
            beat.data  = 8'h00;
            beat.last  = 1'b1;
            beat.error = 1'b1;
        end else begin
            beat.data  = {nib, bl_reg, phase_reg == clcd_pkg::PH_STROBE, 1'b0, ctrl.rs};
            beat.last  = ctrl.last && (phase_reg == clcd_pkg::PH_HOLD) && !jump;
            beat.error = 1'b0;
        end
    end

    assign beat_valid = fire;
    assign busy       = busy_reg;

    // Sequencer next state
    always_comb begin
        busy_next    = busy_reg;
        pc_next      = pc_reg;
        phase_next   = phase_reg;
        row_next     = row_reg;
        bl_next      = bl_reg;
        lastnib_next = lastnib_reg;
        if (start) begin
            busy_next  = 1'b1;
            pc_next    = entry;
            phase_next = clcd_pkg::PH_WRITE;
            row_next   = 3'd0;
            if (!cmd.bad && cmd.func == clcd_pkg::FUNC_INIT) begin
                bl_next = 1'b0;
            end
            if (!cmd.bad && cmd.func == clcd_pkg::FUNC_BACKLIGHT) begin
                bl_next = cmd.backlight_on;
            end
        end else if (fire) begin
            if (!ctrl.err && phase_reg == clcd_pkg::PH_WRITE) begin
                lastnib_next = nib;
            end
            if (step_end) begin
                phase_next = clcd_pkg::PH_WRITE;
                if (jump) begin
                    pc_next  = ctrl.target;
                    row_next = row_reg + 3'd1;
                end else if (ctrl.last) begin
                    busy_next = 1'b0;
                end else begin
                    pc_next = pc_reg + 5'd1;
                end
            end else begin
                phase_next = phase_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            pc_reg      <= '0;
            phase_reg   <= clcd_pkg::PH_WRITE;
            row_reg     <= '0;
            bl_reg      <= 1'b0;
            lastnib_reg <= 4'h0;
        end else begin
            busy_reg    <= busy_next;
            pc_reg      <= pc_next;
            phase_reg   <= phase_next;
            row_reg     <= row_next;
            bl_reg      <= bl_next;
            lastnib_reg <= lastnib_next;
        end
    end

    // Command payload
    always_ff @(posedge aclk) begin
        if (start) begin
            cmd_reg <= cmd;
        end
    end

endmodule

`default_nettype wire

// ===== sv/char_lcd_nibble_command_encoder.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_command_encoder
// Turns display commands into the expander byte stream for a character LCD
// run in 4-bit mode.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one command per beat; s_tuser is the command code, s_tdata
//   carries its operands. m_ channel: one expander byte per beat; m_tlast
//   marks the final byte of a command, m_tuser flags a rejected command
//   (single zero byte). cfg_ channel writes two_line_mode, always ready;
//   write it only while no command is in flight.
//   The command is latched into the sequencer registers, and its first byte
//   then reaches m_tvalid through the output register. Bytes follow one per
//   cycle while m_tready allows. Bytes per command: init 36, print 12,
//   clear 6, backlight 3, glyph 54, error 1. The control store sequencer
//   handles one command at a time: s_tready stays low while a command's
//   bytes are produced, so no new command is taken before the last is done;
//   s_tready rises once its last byte has entered the output register.
//   A stall on m_tready freezes the sequencer; the held byte stays put.
//   Reset clears two_line_mode, the backlight bit and the stored nibble,
//   and drops both valids.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_command_encoder (
    input  wire         aclk,
    input  wire         aresetn,
    // s_tdata: char_code[7:0], line[8], column[13:9], backlight_on[14],
    //          slot[17:15], pattern[81:18], zero pad[87:82]
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [87:0] s_tdata,
    // s_tuser: func[2:0]
    input  wire  [2:0]  s_tuser,
    // m_tdata: expander_byte[7:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    // m_tuser: error[0]
    output logic        m_tuser,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire         cfg_data
);

    logic               two_line_reg;
    logic               m_tvalid_reg;
    clcd_pkg::beat_t    out_reg;

    logic               accept;
    logic               busy;
    logic               beat_take;
    logic               beat_valid;
    clcd_pkg::beat_t    beat;
    clcd_pkg::cmd_t     cmd;

    logic [7:0]         char_code;
    logic               line;
    logic [4:0]         column;
    logic [2:0]         slot;
    logic               row_bit;
    logic [3:0]         col_lo;

    assign char_code = s_tdata[7:0];
    assign line      = s_tdata[8];
    assign column    = s_tdata[13:9];
    assign slot      = s_tdata[17:15];

    assign s_tready  = !busy;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign beat_take = !m_tvalid_reg || m_tready;

    // DDRAM address: 0x80 | row<<6 | column
    always_comb begin
        if (two_line_reg) begin
            row_bit = line;
            col_lo  = column[3:0];
        end else begin
            row_bit = column[3];
            col_lo  = {1'b0, column[2:0]};
        end
    end

    // Command capture
    always_comb begin
        cmd.func         = s_tuser;
        cmd.bad          = (s_tuser > clcd_pkg::FUNC_GLYPH) ||
                           (s_tuser == clcd_pkg::FUNC_PRINT && column > clcd_pkg::COL_MAX);
        cmd.char_code    = char_code;
        cmd.backlight_on = s_tdata[14];
        cmd.pattern      = s_tdata[81:18];
        if (s_tuser == clcd_pkg::FUNC_GLYPH) begin
            cmd.addr = {2'b01, slot, 3'b000};
        end else begin
            cmd.addr = {1'b1, row_bit, 2'b00, col_lo};
        end
    end

    clcd_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (accept),
        .cmd        (cmd),
        .beat_take  (beat_take),
        .busy       (busy),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            two_line_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            two_line_reg <= cfg_data;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (beat_take) begin
            m_tvalid_reg <= beat_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat_valid) begin
            out_reg <= beat;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg.data;
    assign m_tlast  = out_reg.last;
    assign m_tuser  = out_reg.error;

`ifndef SYNTHESIS
    // A rejected command is one zero byte that closes the run
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && m_tdata == 8'h00)
        else $error("error beat not a lone zero byte");

    // The sequencer takes one command at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command accepted while sequencer busy");

    // rw is never driven high
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[1])
        else $error("rw bit set on expander byte");

    // An enable-high byte is followed by the same byte with enable low
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tuser && m_tdata[2] |=>
            m_tvalid && m_tdata == ($past(m_tdata) & 8'hFB))
        else $error("strobe not followed by hold byte");
`endif

endmodule

`default_nettype wire

// ===== sim/char_lcd_nibble_command_encoder_test.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_command_encoder_test
// Self-checking bench for the character-LCD nibble command encoder. A
// scoreboard works out the expander byte run of every accepted command and
// compares each output beat against it. Directed commands cover the field
// extremes, every command and both line modes. Random commands follow, with
// random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module char_lcd_nibble_command_encoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int MAX_GAP        = 14;
    localparam int RANDOM_PHASES  = 4;
    localparam int PHASE_COMMANDS = 40;
    localparam int HOLD_AFTER     = 60;     // commands accepted before the long stall
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 20;
    // Longest quiet stretch in a good run is the long stall plus a few gaps
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    // Command codes the block rejects
    localparam logic [2:0] FUNC_RSVD_FIRST = 3'd5;
    localparam logic [2:0] FUNC_RSVD_LAST  = 3'd7;

    // Display constants
    localparam logic [7:0] DDRAM_BASE   = 8'h80;
    localparam logic [7:0] DDRAM_LINE2  = 8'hC0;
    localparam logic [7:0] LINE_OFFSET  = 8'h40;
    localparam logic [7:0] CGRAM_BASE   = 8'h40;
    localparam logic [4:0] HALF_COLUMNS = 5'd8;
    localparam logic [3:0] WAKE_NIBBLE  = 4'h3;
    localparam logic [3:0] MODE4_NIBBLE = 4'h2;
    localparam logic [7:0] FUNCTION_SET = 8'h28;
    localparam logic [7:0] DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] CLEAR_CMD    = 8'h01;
    localparam logic [7:0] ENTRY_MODE   = 8'h06;
    localparam logic [7:0] ENABLE_BIT   = 8'h04;
    localparam int         GLYPH_ROWS   = 8;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow state plus the queue of expander bytes still owed
    // ------------------------------------------------------------------------
    class lcd_scoreboard;
        logic            two_line;
        logic            backlight;
        logic [3:0]      last_nib;
        clcd_pkg::beat_t owed_bytes[$];
        int              faults;
        int              bytes_checked;
        int              error_beats;

        function new();
            two_line      = 1'b0;
            backlight     = 1'b0;
            last_nib      = 4'h0;
            faults        = 0;
            bytes_checked = 0;
            error_beats   = 0;
        endfunction

        function void set_line_mode(logic mode);
            two_line = mode;
        endfunction

        function int owed();
            return owed_bytes.size();
        endfunction

        // write, strobe, hold for one nibble
        function void push_nibble(logic [3:0] nib, logic rs);
            clcd_pkg::beat_t b;
            last_nib = nib;
            b        = '0;
            b.data   = {nib, backlight, 1'b0, 1'b0, rs};
            owed_bytes.push_back(b);
            b.data   = b.data | ENABLE_BIT;
            owed_bytes.push_back(b);
            b.data   = b.data & ~ENABLE_BIT;
            owed_bytes.push_back(b);
        endfunction

        function void push_byte(logic [7:0] v, logic rs);
            push_nibble(v[7:4], rs);
            push_nibble(v[3:0], rs);
        endfunction

        // Work out the byte run of one accepted command
        function void encode_command(logic [2:0] func, logic [7:0] ch, logic ln,
                                     logic [4:0] col, logic bl, logic [2:0] slot,
                                     logic [63:0] pat);
            clcd_pkg::beat_t b;
            logic [7:0]      addr;
            if (func > clcd_pkg::FUNC_GLYPH ||
                (func == clcd_pkg::FUNC_PRINT && col > clcd_pkg::COL_MAX)) begin
                b       = '0;
                b.last  = 1'b1;
                b.error = 1'b1;
                owed_bytes.push_back(b);
                return;
            end
            case (func)
                clcd_pkg::FUNC_INIT: begin
                    backlight = 1'b0;
                    push_nibble(WAKE_NIBBLE, 1'b0);
                    push_nibble(WAKE_NIBBLE, 1'b0);
                    push_nibble(WAKE_NIBBLE, 1'b0);
                    push_nibble(MODE4_NIBBLE, 1'b0);
                    push_byte(FUNCTION_SET, 1'b0);
                    push_byte(DISPLAY_ON, 1'b0);
                    push_byte(CLEAR_CMD, 1'b0);
                    push_byte(ENTRY_MODE, 1'b0);
                end
                clcd_pkg::FUNC_PRINT: begin
                    if (two_line)
                        addr = DDRAM_BASE + (ln ? LINE_OFFSET : 8'h00) + 8'(col);
                    else if (col < HALF_COLUMNS)
                        addr = DDRAM_BASE + 8'(col);
                    else
                        addr = DDRAM_LINE2 + 8'(col - HALF_COLUMNS);
                    push_byte(addr, 1'b0);
                    push_byte(ch, 1'b1);
                end
                clcd_pkg::FUNC_CLEAR: push_byte(CLEAR_CMD, 1'b0);
                clcd_pkg::FUNC_BACKLIGHT: begin
                    backlight = bl;
                    push_nibble(last_nib, 1'b0);
                end
                default: begin
                    push_byte(CGRAM_BASE + {2'b00, slot, 3'b000}, 1'b0);
                    for (int r = 0; r < GLYPH_ROWS; r++)
                        push_byte(pat[8*r +: 8], 1'b1);
                end
            endcase
            // flag the final byte of the run
            b      = owed_bytes.pop_back();
            b.last = 1'b1;
            owed_bytes.push_back(b);
        endfunction

        function void report(string what, clcd_pkg::beat_t want, clcd_pkg::beat_t got);
            faults++;
            if (faults <= MAX_REPORTS)
                $display("%0t: %s: expected byte %02h last %0b err %0b, %s",
                         $realtime, what, want.data, want.last, want.error,
                         $sformatf("got byte %02h last %0b err %0b",
                                   got.data, got.last, got.error));
        endfunction

        // Compare one output beat with the oldest owed byte
        function void check_byte(logic [7:0] data, logic last, logic error);
            clcd_pkg::beat_t got;
            clcd_pkg::beat_t want;
            got       = '0;
            got.data  = data;
            got.last  = last;
            got.error = error;
            if (owed_bytes.size() == 0) begin
                report("unexpected byte", '0, got);
                return;
            end
            want = owed_bytes.pop_front();
            bytes_checked++;
            if (want.error)
                error_beats++;
            if (got.data !== want.data || got.last !== want.last || got.error !== want.error)
                report("byte mismatch", want, got);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;    // char_code, line, column, backlight_on, slot, pattern, pad
    logic [2:0]  s_tuser;    // func
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;    // expander_byte
    logic        m_tlast;
    logic        m_tuser;    // error
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;

    char_lcd_nibble_command_encoder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    lcd_scoreboard sb = new();

    int  cmds_accepted = 0;
    int  mode_writes   = 0;
    int  kind_count[8];
    bit  no_idle       = 1'b0;
    bit  hold_done     = 1'b0;

    // Clock
    initial begin
        aclk = 1'b0;
        forever #(CLK_HALF) aclk = ~aclk;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Offer one command, wait for its beat, then idle for a random gap
    task automatic issue_command(input logic [2:0] func, input logic [7:0] ch,
                                 input logic ln, input logic [4:0] col,
                                 input logic bl, input logic [2:0] slot,
                                 input logic [63:0] pat);
        int gap;
        s_tuser  <= func;
        s_tdata  <= {6'b0, pat, slot, bl, col, ln, ch};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.encode_command(func, ch, ln, col, bl, slot, pat);
        cmds_accepted++;
        kind_count[func]++;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
    endtask

    // Mostly legal commands; some rejected columns and unknown codes
    task automatic random_command();
        int          pick;
        logic [2:0]  func;
        logic [4:0]  col;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            func = clcd_pkg::FUNC_INIT;
        else if (pick < 45)
            func = clcd_pkg::FUNC_PRINT;
        else if (pick < 55)
            func = clcd_pkg::FUNC_CLEAR;
        else if (pick < 70)
            func = clcd_pkg::FUNC_BACKLIGHT;
        else if (pick < 90)
            func = clcd_pkg::FUNC_GLYPH;
        else
            func = 3'($urandom_range(FUNC_RSVD_FIRST, FUNC_RSVD_LAST));
        if (func == clcd_pkg::FUNC_PRINT && $urandom_range(0, 99) < 85)
            col = 5'($urandom_range(0, clcd_pkg::COL_MAX));
        else
            col = 5'($urandom_range(0, 31));
        issue_command(func, 8'($urandom), 1'($urandom), col, 1'($urandom),
                      3'($urandom), {$urandom, $urandom});
    endtask

    // Line-mode write, only once every owed byte has come out
    task automatic write_line_mode(input logic mode);
        while (sb.owed() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_data  <= mode;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.set_line_mode(mode);
        mode_writes++;
    endtask

    // ------------------------------------------------------------------------
    // Output side: random ready gaps per beat, one long hold-off
    // ------------------------------------------------------------------------
    initial begin : drain_side
        int gap;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (!hold_done && cmds_accepted >= HOLD_AFTER) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            gap = draw_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready))
                @(posedge aclk);
        end
    end

    // Output monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_byte(m_tdata, m_tlast, m_tuser);
    end

    // Watchdog on cycles with no beat anywhere
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: watchdog: no beat for %0d cycles, %0d bytes still owed",
                 $realtime, WATCHDOG_LIMIT, sb.owed());
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int leftover;
        int total_faults;
        foreach (kind_count[k])
            kind_count[k] = 0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= clcd_pkg::FUNC_INIT;
        cfg_valid <= 1'b0;
        cfg_data  <= 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, one-line mode
        write_line_mode(1'b0);
        // backlight right after reset resends the cleared nibble
        issue_command(clcd_pkg::FUNC_BACKLIGHT, 8'h00, 1'b0, 5'd0,  1'b1, 3'd0, 64'h0);
        issue_command(clcd_pkg::FUNC_INIT,      8'h00, 1'b0, 5'd0,  1'b0, 3'd0, 64'h0);
        issue_command(clcd_pkg::FUNC_BACKLIGHT, 8'hFF, 1'b1, 5'd31, 1'b1, 3'd7, '1);
        issue_command(clcd_pkg::FUNC_PRINT,     8'h00, 1'b0, 5'd0,  1'b0, 3'd0, 64'h0);
        // line is ignored in one-line mode
        issue_command(clcd_pkg::FUNC_PRINT,     8'hFF, 1'b1, 5'd7,  1'b0, 3'd0, 64'h0);
        issue_command(clcd_pkg::FUNC_PRINT,     8'h41, 1'b1, 5'd8,  1'b1, 3'd7, '1);
        issue_command(clcd_pkg::FUNC_PRINT, 8'h7E, 1'b0, clcd_pkg::COL_MAX, 1'b0, 3'd0, 64'h0);
        // columns past the edge are rejected
        issue_command(clcd_pkg::FUNC_PRINT,     8'h33, 1'b0, 5'd16, 1'b0, 3'd0, 64'h0);
        issue_command(clcd_pkg::FUNC_PRINT,     8'hFF, 1'b1, 5'd31, 1'b1, 3'd7, '1);
        issue_command(clcd_pkg::FUNC_CLEAR,     8'hFF, 1'b1, 5'd31, 1'b1, 3'd7, '1);
        issue_command(clcd_pkg::FUNC_BACKLIGHT, 8'h00, 1'b0, 5'd0,  1'b0, 3'd0, 64'h0);
        issue_command(clcd_pkg::FUNC_GLYPH,     8'h00, 1'b0, 5'd0,  1'b0, 3'd0, 64'h0);
        issue_command(clcd_pkg::FUNC_GLYPH,     8'hFF, 1'b1, 5'd31, 1'b1, 3'd7, '1);
        issue_command(clcd_pkg::FUNC_GLYPH, 8'h12, 1'b0, 5'd3, 1'b1, 3'd5,
                      64'h0123456789ABCDEF);
        // unknown command codes
        issue_command(FUNC_RSVD_FIRST, 8'hA5, 1'b1, 5'd9, 1'b1, 3'd2, 64'hDEADBEEF00FF00FF);
        issue_command(FUNC_RSVD_FIRST + 3'd1, 8'h5A, 1'b0, 5'd20, 1'b0, 3'd6, 64'h0);
        issue_command(FUNC_RSVD_LAST,         8'hFF, 1'b1, 5'd31, 1'b1, 3'd7, '1);
        // init drops the backlight again
        issue_command(clcd_pkg::FUNC_BACKLIGHT, 8'h00, 1'b0, 5'd0,  1'b1, 3'd0, 64'h0);
        issue_command(clcd_pkg::FUNC_INIT,      8'hFF, 1'b1, 5'd31, 1'b1, 3'd7, '1);
        end_burst();

        // Directed, two-line mode
        write_line_mode(1'b1);
        issue_command(clcd_pkg::FUNC_PRINT, 8'h55, 1'b0, 5'd0, 1'b0, 3'd0, 64'h0);
        issue_command(clcd_pkg::FUNC_PRINT, 8'hAA, 1'b1, clcd_pkg::COL_MAX, 1'b1, 3'd0, 64'h0);
        issue_command(clcd_pkg::FUNC_PRINT, 8'h30, 1'b1, 5'd0, 1'b0, 3'd0, 64'h0);
        issue_command(clcd_pkg::FUNC_PRINT, 8'h39, 1'b0, clcd_pkg::COL_MAX, 1'b0, 3'd0, 64'h0);
        issue_command(clcd_pkg::FUNC_PRINT, 8'h20, 1'b1, 5'd16, 1'b0, 3'd0, 64'h0);
        end_burst();

        // Random phases alternating the line mode; one without idling
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_line_mode(1'(p));
            no_idle = (p == 1);
            repeat (PHASE_COMMANDS) random_command();
            end_burst();
        end
        no_idle = 1'b0;

        // Drain, then a short tail to catch stray bytes
        while (sb.owed() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        leftover     = sb.owed();
        total_faults = sb.faults + leftover;
        $display("Covered %0d commands (init %0d, print %0d, clear %0d, backlight %0d, glyph %0d)",
                 cmds_accepted, kind_count[clcd_pkg::FUNC_INIT],
                 kind_count[clcd_pkg::FUNC_PRINT], kind_count[clcd_pkg::FUNC_CLEAR],
                 kind_count[clcd_pkg::FUNC_BACKLIGHT], kind_count[clcd_pkg::FUNC_GLYPH]);
        $display("%0d bytes checked, %0d rejections, %0d mode writes, %0d faults, %0d owed",
                 sb.bytes_checked, sb.error_beats, mode_writes, sb.faults, leftover);
        if (total_faults == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
